>>> hdl/json_string_unescaper_assert.svh
// assertion macros for the json string unescaper
`ifndef JSON_STRING_UNESCAPER_ASSERT_SVH
`define JSON_STRING_UNESCAPER_ASSERT_SVH

`ifndef SYNTHESIS

`define JSU_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

`define JSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define JSU_ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`define JSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> hdl/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

	localparam logic [1:0] MODE_PLAIN  = 2'd0;
	localparam logic [1:0] MODE_ESCAPE = 2'd1;
	localparam logic [1:0] MODE_HEX    = 2'd2;

	localparam logic [7:0] HIGH_BIT    = 8'h80;
	localparam logic [7:0] QUOTE_CHAR  = 8'h22;
	localparam logic [7:0] BSLASH_CHAR = 8'h5c;
	localparam logic [7:0] SLASH_CHAR  = 8'h2f;
	localparam int         HEX_DIGITS  = 4;

	// escape letters and the control characters they stand for
	localparam logic [7:0] ESC_B_CHAR  = 8'h62;
	localparam logic [7:0] ESC_F_CHAR  = 8'h66;
	localparam logic [7:0] ESC_N_CHAR  = 8'h6e;
	localparam logic [7:0] ESC_R_CHAR  = 8'h72;
	localparam logic [7:0] ESC_T_CHAR  = 8'h74;
	localparam logic [7:0] ESC_U_CHAR  = 8'h75;
	localparam logic [7:0] BS_CTRL     = 8'h08;
	localparam logic [7:0] FF_CTRL     = 8'h0c;
	localparam logic [7:0] LF_CTRL     = 8'h0a;
	localparam logic [7:0] CR_CTRL     = 8'h0d;
	localparam logic [7:0] HT_CTRL     = 8'h09;

	localparam logic [0:0] KIND_DATA = 1'b0;
	localparam logic [0:0] KIND_END  = 1'b1;

	typedef struct packed {
		logic [1:0]      cnt;
		logic            kind;
		logic [2:0][7:0] data;
	} res_t;

	// returns {is_hex, nibble}
	function automatic logic [4:0] hex_val(input logic [7:0] b);
		logic [4:0] r;
		begin
			r = 5'd0;
			if (b >= 8'h30 && b <= 8'h39) begin
				r = {1'b1, 4'(b - 8'h30)};
			end else if (b >= 8'h41 && b <= 8'h46) begin
				r = {1'b1, 4'(b - 8'h37)};
			end else if (b >= 8'h61 && b <= 8'h66) begin
				r = {1'b1, 4'(b - 8'h57)};
			end
			return r;
		end
	endfunction

endpackage

`default_nettype wire

>>> hdl/jsu_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         fire,
	input  wire logic [7:0]   byte_in,
	output jsu_pkg::res_t     res
);

	logic [1:0]  mode_q;
	logic [1:0]  hex_count_q;
	logic [15:0] accum_q;
	logic        bad_q;

	logic [1:0]  mode_d;
	logic [1:0]  hex_count_d;
	logic [15:0] accum_d;
	logic        bad_d;
	logic [4:0]  hv;

	always_comb begin
		mode_d      = mode_q;
		hex_count_d = hex_count_q;
		accum_d     = accum_q;
		bad_d       = bad_q;
		res         = '0;
		hv          = jsu_pkg::hex_val(byte_in);
		case (mode_q)
			jsu_pkg::MODE_ESCAPE: begin
				mode_d = jsu_pkg::MODE_PLAIN;
				res.cnt = 2'd1;
				case (byte_in)
					jsu_pkg::QUOTE_CHAR:  res.data[0] = jsu_pkg::QUOTE_CHAR;
					jsu_pkg::BSLASH_CHAR: res.data[0] = jsu_pkg::BSLASH_CHAR;
					jsu_pkg::SLASH_CHAR:  res.data[0] = jsu_pkg::SLASH_CHAR;
					jsu_pkg::ESC_B_CHAR:  res.data[0] = jsu_pkg::BS_CTRL;
					jsu_pkg::ESC_F_CHAR:  res.data[0] = jsu_pkg::FF_CTRL;
					jsu_pkg::ESC_N_CHAR:  res.data[0] = jsu_pkg::LF_CTRL;
					jsu_pkg::ESC_R_CHAR:  res.data[0] = jsu_pkg::CR_CTRL;
					jsu_pkg::ESC_T_CHAR:  res.data[0] = jsu_pkg::HT_CTRL;
					jsu_pkg::ESC_U_CHAR: begin
						res.cnt     = 2'd0;
						mode_d      = jsu_pkg::MODE_HEX;
						hex_count_d = 2'd0;
						accum_d     = 16'd0;
						bad_d       = 1'b0;
					end
					default:              res.cnt = 2'd0;
				endcase
			end
			jsu_pkg::MODE_HEX: begin
				if (hv[4]) begin
					accum_d = {accum_q[11:0], hv[3:0]};
				end else begin
					bad_d = 1'b1;
				end
				if (hex_count_q == 2'(jsu_pkg::HEX_DIGITS - 1)) begin
					mode_d      = jsu_pkg::MODE_PLAIN;
					hex_count_d = 2'd0;
					if (!bad_d) begin
						if (accum_d < 16'h0080) begin
							res.cnt     = 2'd1;
							res.data[0] = accum_d[7:0];
						end else if (accum_d < 16'h0800) begin
							res.cnt     = 2'd2;
							res.data[0] = {3'b110, accum_d[10:6]};
							res.data[1] = {2'b10, accum_d[5:0]};
						end else begin
							res.cnt     = 2'd3;
							res.data[0] = {4'b1110, accum_d[15:12]};
							res.data[1] = {2'b10, accum_d[11:6]};
							res.data[2] = {2'b10, accum_d[5:0]};
						end
					end
				end else begin
					hex_count_d = hex_count_q + 2'd1;
				end
			end
			default: begin
				mode_d  = jsu_pkg::MODE_PLAIN;
				res.cnt = 2'd1;
				if ((byte_in & jsu_pkg::HIGH_BIT) != 8'd0) begin
					res.data[0] = byte_in;
				end else if (byte_in == jsu_pkg::BSLASH_CHAR) begin
					res.cnt = 2'd0;
					mode_d  = jsu_pkg::MODE_ESCAPE;
				end else if (byte_in == jsu_pkg::QUOTE_CHAR) begin
					res.kind = jsu_pkg::KIND_END;
				end else begin
					res.data[0] = byte_in;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= jsu_pkg::MODE_PLAIN;
			hex_count_q <= 2'd0;
			accum_q     <= 16'd0;
			bad_q       <= 1'b0;
		end else if (fire) begin
			mode_q      <= mode_d;
			hex_count_q <= hex_count_d;
			accum_q     <= accum_d;
			bad_q       <= bad_d;
		end
	end

endmodule

`default_nettype wire

>>> hdl/jsu_out.sv
`timescale 1ns / 1ps
`default_nettype none

`include "json_string_unescaper_assert.svh"

module jsu_out (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         load,
	input  jsu_pkg::res_t     res,
	output logic              free,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tuser,
	output logic              m_tlast
);

	jsu_pkg::res_t grp_q;
	logic          valid_q;
	logic [1:0]    idx_q;

	assign m_tvalid = valid_q;
	assign m_tdata  = grp_q.data[idx_q];
	assign m_tuser  = grp_q.kind;
	assign m_tlast  = (idx_q == grp_q.cnt - 2'd1);
	assign free     = !valid_q || (m_tready && m_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= (res.cnt != 2'd0);
			idx_q   <= 2'd0;
		end else if (valid_q && m_tready) begin
			if (m_tlast) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_q <= res;
		end
	end

	// group bookkeeping
	`JSU_ASSERT_IMPL(a_idx_in_range, clk, arst_n, valid_q, idx_q < grp_q.cnt)
	`JSU_ASSERT_IMPL(a_end_alone, clk, arst_n, valid_q && m_tuser,
		grp_q.cnt == 2'd1 && m_tdata == 8'd0)
	`JSU_ASSERT_NEXT(a_group_continues, clk, arst_n, valid_q && m_tready && !m_tlast,
		valid_q && idx_q == $past(idx_q) + 2'd1)
	`JSU_ASSERT_IMPL(a_no_load_busy, clk, arst_n, load, free)

endmodule

`default_nettype wire

>>> hdl/json_string_unescaper.sv
// json string unescaper: one raw string byte in, zero to three decoded bytes out
// data path: the input register feeds the combinational decode, whose result group register drives the output
// throughput: one input byte per cycle unless m_tready is low or a multi-byte escape group drains
// reset: arst_n asynchronous active low, clears valid flags and returns decoding to plain mode
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescaper (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,  // [7:0] in_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,  // [7:0] out_byte
	output logic            m_tuser,  // [0] out_kind
	output logic            m_tlast
);

	logic          vld_s1;
	logic [7:0]    byte_s1;
	logic          free;
	logic          fire;
	jsu_pkg::res_t res;

	assign fire     = vld_s1 && free;
	assign s_tready = !vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	jsu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_in (byte_s1),
		.res     (res)
	);

	jsu_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire),
		.res      (res),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire
